### design/kwq_pkg.sv
// Shared types, constants and look-up tables of the Morse keyer with queue.
// Used by kwq_cmd_front, kwq_keyer_back and morse_keyer_with_queue.
`timescale 1ns / 1ps
`default_nettype none

package kwq_pkg;

   localparam int QUEUE_DEPTH = 512;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int FILL_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = 9;
   localparam int CHAR_W      = 8;
   localparam int CMD_W       = 2;
   localparam int DOT_W       = 8;
   localparam int INTV_W      = 10;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 6;
   localparam int WPM_W       = 6;

   localparam int CQ_DEPTH = 2;
   localparam int CQ_IDX_W = 1;
   localparam int CQ_CNT_W = 2;

   localparam logic [WPM_W-1:0]  WPM_RESET   = 6'd20;
   localparam logic [DOT_W-1:0]  DOT_DEFAULT = 8'd60;
   localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;

   localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STOP = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_WPM     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_DTR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ENABLE  = 2'd2;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_PUSH,
      OP_STOP,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [CHAR_W-1:0] char_code;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } front_type;

   typedef struct packed {
      logic       known;
      logic [2:0] length;
      logic [5:0] pattern;
   } morse_code_type;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   // Dot length in ticks for a given speed; speeds outside 5 to 60 count as 20.
   function automatic logic [DOT_W-1:0] dot_ticks_of(input logic [WPM_W-1:0] wpm);
      logic [DOT_W-1:0] d;
      begin
         case (wpm)
            6'd5:    d = 8'd240;
            6'd6:    d = 8'd200;
            6'd7:    d = 8'd171;
            6'd8:    d = 8'd150;
            6'd9:    d = 8'd133;
            6'd10:   d = 8'd120;
            6'd11:   d = 8'd109;
            6'd12:   d = 8'd100;
            6'd13:   d = 8'd92;
            6'd14:   d = 8'd85;
            6'd15:   d = 8'd80;
            6'd16:   d = 8'd75;
            6'd17:   d = 8'd70;
            6'd18:   d = 8'd66;
            6'd19:   d = 8'd63;
            6'd20:   d = 8'd60;
            6'd21:   d = 8'd57;
            6'd22:   d = 8'd54;
            6'd23:   d = 8'd52;
            6'd24:   d = 8'd50;
            6'd25:   d = 8'd48;
            6'd26:   d = 8'd46;
            6'd27:   d = 8'd44;
            6'd28:   d = 8'd42;
            6'd29:   d = 8'd41;
            6'd30:   d = 8'd40;
            6'd31:   d = 8'd38;
            6'd32:   d = 8'd37;
            6'd33:   d = 8'd36;
            6'd34:   d = 8'd35;
            6'd35:   d = 8'd34;
            6'd36:   d = 8'd33;
            6'd37:   d = 8'd32;
            6'd38:   d = 8'd31;
            6'd39:   d = 8'd30;
            6'd40:   d = 8'd30;
            6'd41:   d = 8'd29;
            6'd42:   d = 8'd28;
            6'd43:   d = 8'd27;
            6'd44:   d = 8'd27;
            6'd45:   d = 8'd26;
            6'd46:   d = 8'd26;
            6'd47:   d = 8'd25;
            6'd48:   d = 8'd25;
            6'd49:   d = 8'd24;
            6'd50:   d = 8'd24;
            6'd51:   d = 8'd23;
            6'd52:   d = 8'd23;
            6'd53:   d = 8'd22;
            6'd54:   d = 8'd22;
            6'd55:   d = 8'd21;
            6'd56:   d = 8'd21;
            6'd57:   d = 8'd21;
            6'd58:   d = 8'd20;
            6'd59:   d = 8'd20;
            6'd60:   d = 8'd20;
            default: d = DOT_DEFAULT;
         endcase
         return d;
      end
   endfunction

   // Pattern bit 0 is the first element; a set bit is a dash.
   function automatic morse_code_type code_of(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] up;
      morse_code_type    code;
      begin
         up = c;
         if (c inside {[8'h61:8'h7A]}) begin
            up = c - 8'h20;
         end
         case (up)
            8'h41:   code = '{1'b1, 3'd2, 6'b000010};
            8'h42:   code = '{1'b1, 3'd4, 6'b000001};
            8'h43:   code = '{1'b1, 3'd4, 6'b000101};
            8'h44:   code = '{1'b1, 3'd3, 6'b000001};
            8'h45:   code = '{1'b1, 3'd1, 6'b000000};
            8'h46:   code = '{1'b1, 3'd4, 6'b000100};
            8'h47:   code = '{1'b1, 3'd3, 6'b000011};
            8'h48:   code = '{1'b1, 3'd4, 6'b000000};
            8'h49:   code = '{1'b1, 3'd2, 6'b000000};
            8'h4A:   code = '{1'b1, 3'd4, 6'b001110};
            8'h4B:   code = '{1'b1, 3'd3, 6'b000101};
            8'h4C:   code = '{1'b1, 3'd4, 6'b000010};
            8'h4D:   code = '{1'b1, 3'd2, 6'b000011};
            8'h4E:   code = '{1'b1, 3'd2, 6'b000001};
            8'h4F:   code = '{1'b1, 3'd3, 6'b000111};
            8'h50:   code = '{1'b1, 3'd4, 6'b000110};
            8'h51:   code = '{1'b1, 3'd4, 6'b001011};
            8'h52:   code = '{1'b1, 3'd3, 6'b000010};
            8'h53:   code = '{1'b1, 3'd3, 6'b000000};
            8'h54:   code = '{1'b1, 3'd1, 6'b000001};
            8'h55:   code = '{1'b1, 3'd3, 6'b000100};
            8'h56:   code = '{1'b1, 3'd4, 6'b001000};
            8'h57:   code = '{1'b1, 3'd3, 6'b000110};
            8'h58:   code = '{1'b1, 3'd4, 6'b001001};
            8'h59:   code = '{1'b1, 3'd4, 6'b001101};
            8'h5A:   code = '{1'b1, 3'd4, 6'b000011};
            8'h30:   code = '{1'b1, 3'd5, 6'b011111};
            8'h31:   code = '{1'b1, 3'd5, 6'b011110};
            8'h32:   code = '{1'b1, 3'd5, 6'b011100};
            8'h33:   code = '{1'b1, 3'd5, 6'b011000};
            8'h34:   code = '{1'b1, 3'd5, 6'b010000};
            8'h35:   code = '{1'b1, 3'd5, 6'b000000};
            8'h36:   code = '{1'b1, 3'd5, 6'b000001};
            8'h37:   code = '{1'b1, 3'd5, 6'b000011};
            8'h38:   code = '{1'b1, 3'd5, 6'b000111};
            8'h39:   code = '{1'b1, 3'd5, 6'b001111};
            8'h2E:   code = '{1'b1, 3'd6, 6'b101010};
            8'h2C:   code = '{1'b1, 3'd6, 6'b110011};
            8'h3F:   code = '{1'b1, 3'd6, 6'b001100};
            8'h2F:   code = '{1'b1, 3'd5, 6'b001001};
            8'h2D:   code = '{1'b1, 3'd6, 6'b100001};
            8'h3D:   code = '{1'b1, 3'd5, 6'b010001};
            8'h2B:   code = '{1'b1, 3'd5, 6'b001010};
            default: code = '{1'b0, 3'd0, 6'b000000};
         endcase
         return code;
      end
   endfunction

endpackage

`default_nettype wire

### design/kwq_cmd_front.sv
// Command front end: takes request transfers, classifies them and holds them
// in a two-entry command queue for the keyer back end. Depends on kwq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kwq_cmd_front (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire  [kwq_pkg::CMD_W-1:0]      req_cmd,
   input  wire  [kwq_pkg::CHAR_W-1:0]     req_char_code,
   output kwq_pkg::front_type             front,
   input  wire                            take
);

   kwq_pkg::cmd_type                  slot_ff [kwq_pkg::CQ_DEPTH];
   logic [kwq_pkg::CQ_IDX_W-1:0]      rd_ff, rd_in;
   logic [kwq_pkg::CQ_IDX_W-1:0]      wr_ff, wr_in;
   logic [kwq_pkg::CQ_CNT_W-1:0]      count_ff, count_in;
   kwq_pkg::cmd_type                  entry;
   logic                              push;
   logic                              pop;

   always_comb begin
      entry.char_code = req_char_code;
      case (req_cmd)
         kwq_pkg::CMD_TICK: entry.op = kwq_pkg::OP_TICK;
         kwq_pkg::CMD_PUSH: entry.op = kwq_pkg::OP_PUSH;
         kwq_pkg::CMD_STOP: entry.op = kwq_pkg::OP_STOP;
         default:           entry.op = kwq_pkg::OP_NONE;
      endcase
   end

   assign req_stall   = (count_ff == kwq_pkg::CQ_CNT_W'(kwq_pkg::CQ_DEPTH));
   assign push        = req_valid && !req_stall;
   assign pop         = (count_ff != '0) && take;
   assign front.valid = (count_ff != '0);
   assign front.cmd   = slot_ff[rd_ff];

   always_comb begin
      rd_in    = pop  ? rd_ff + kwq_pkg::CQ_IDX_W'(1) : rd_ff;
      wr_in    = push ? wr_ff + kwq_pkg::CQ_IDX_W'(1) : wr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + kwq_pkg::CQ_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - kwq_pkg::CQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff    <= '0;
         wr_ff    <= '0;
         count_ff <= '0;
      end else begin
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

### design/kwq_keyer_back.sv
// Keyer back end: configuration registers, character store, keying timer and
// the registered response stage. Depends on kwq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kwq_keyer_back (
   input  wire                               clock,
   input  wire                               reset,
   input  kwq_pkg::front_type                front,
   output logic                              take,
   input  wire                               csr_write_enable,
   input  wire  [kwq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [kwq_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic                              rsp_key_down,
   output logic                              rsp_dtr_line,
   output logic                              rsp_rts_line,
   output logic                              rsp_accepted,
   output logic [kwq_pkg::QFILL_W-1:0]       rsp_queue_fill,
   output logic                              rsp_sending
);

   localparam int PTR_W   = kwq_pkg::PTR_W;
   localparam int FILL_W  = kwq_pkg::FILL_W;
   localparam int QFILL_W = kwq_pkg::QFILL_W;
   localparam int INTV_W  = kwq_pkg::INTV_W;
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(kwq_pkg::QUEUE_DEPTH - 1);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_MARK,
      PH_GAP,
      PH_CHARGAP,
      PH_SPACE
   } phase_type;

   logic [kwq_pkg::CHAR_W-1:0]  store_mem [kwq_pkg::QUEUE_DEPTH];
   logic [kwq_pkg::CHAR_W-1:0]  head_ff;

   logic [kwq_pkg::WPM_W-1:0]   wpm_ff, wpm_in;
   logic                        key_dtr_ff, key_dtr_in;
   logic                        enable_ff, enable_in;
   logic [PTR_W-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [FILL_W-1:0]           fill_ff, fill_in;
   phase_type                   phase_ff, phase_in;
   logic [5:0]                  pattern_ff, pattern_in;
   logic [2:0]                  left_ff, left_in;
   logic [INTV_W-1:0]           count_ff, count_in;
   logic [kwq_pkg::DOT_W-1:0]   dot_ff, dot_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        key_ff, key_in;
   logic                        dtr_ff, dtr_in;
   logic                        rts_ff, rts_in;
   logic                        accepted_ff, accepted_in;
   logic [QFILL_W-1:0]          qfill_ff, qfill_in;
   logic                        sending_ff, sending_in;

   logic                        exec;
   logic                        store_we;
   logic                        do_pop;
   logic [INTV_W-1:0]           count_dec;
   logic                        count_zero;
   logic [INTV_W-1:0]           dot_x1;
   logic [INTV_W-1:0]           dot_x2;
   logic [kwq_pkg::DOT_W-1:0]   dot_new;
   logic [INTV_W-1:0]           new_x1;
   logic [INTV_W-1:0]           new_x3;
   logic [INTV_W-1:0]           new_x4;
   kwq_pkg::morse_code_type     head_code;

   assign take      = exec;
   assign exec      = front.valid && (!rsp_valid_ff || !rsp_stall);
   assign count_dec = (count_ff == '0) ? '0 : count_ff - INTV_W'(1);
   assign count_zero = (count_dec == '0);
   assign dot_x1    = {2'b00, dot_ff};
   assign dot_x2    = {1'b0, dot_ff, 1'b0};
   assign dot_new   = kwq_pkg::dot_ticks_of(wpm_ff);
   assign new_x1    = {2'b00, dot_new};
   assign new_x3    = {1'b0, dot_new, 1'b0} + {2'b00, dot_new};
   assign new_x4    = {dot_new, 2'b00};
   assign head_code = kwq_pkg::code_of(head_ff);

   always_comb begin
      wpm_in     = wpm_ff;
      key_dtr_in = key_dtr_ff;
      enable_in  = enable_ff;
      rd_ptr_in  = rd_ptr_ff;
      wr_ptr_in  = wr_ptr_ff;
      fill_in    = fill_ff;
      phase_in   = phase_ff;
      pattern_in = pattern_ff;
      left_in    = left_ff;
      count_in   = count_ff;
      dot_in     = dot_ff;
      accepted_in = 1'b0;
      store_we   = 1'b0;
      do_pop     = 1'b0;

      if (exec) begin
         case (front.cmd.op)
            kwq_pkg::OP_TICK: begin
               if (enable_ff) begin
                  case (phase_ff)
                     PH_IDLE: begin
                        do_pop = 1'b1;
                     end
                     PH_MARK: begin
                        count_in = count_dec;
                        if (count_zero) begin
                           phase_in = PH_GAP;
                           count_in = dot_x1;
                        end
                     end
                     PH_GAP: begin
                        count_in = count_dec;
                        if (count_zero) begin
                           if (left_ff != 3'd0) begin
                              count_in   = pattern_ff[0] ? dot_x1 + dot_x2 : dot_x1;
                              pattern_in = pattern_ff >> 1;
                              left_in    = left_ff - 3'd1;
                              phase_in   = PH_MARK;
                           end else begin
                              phase_in = PH_CHARGAP;
                              count_in = dot_x2;
                           end
                        end
                     end
                     PH_CHARGAP, PH_SPACE: begin
                        count_in = count_dec;
                        if (count_zero) begin
                           phase_in   = PH_IDLE;
                           pattern_in = '0;
                           left_in    = '0;
                           count_in   = '0;
                           do_pop     = 1'b1;
                        end
                     end
                     default: begin
                        phase_in   = PH_IDLE;
                        pattern_in = '0;
                        left_in    = '0;
                        count_in   = '0;
                     end
                  endcase
               end
            end
            kwq_pkg::OP_PUSH: begin
               if (enable_ff && (fill_ff < FILL_MAX)) begin
                  store_we    = 1'b1;
                  wr_ptr_in   = kwq_pkg::next_ptr(wr_ptr_ff);
                  fill_in     = fill_ff + FILL_W'(1);
                  accepted_in = 1'b1;
               end
            end
            kwq_pkg::OP_STOP: begin
               rd_ptr_in  = '0;
               wr_ptr_in  = '0;
               fill_in    = '0;
               phase_in   = PH_IDLE;
               pattern_in = '0;
               left_in    = '0;
               count_in   = '0;
            end
            default: begin
            end
         endcase
      end

      // A pop takes the head character; an unknown one is simply dropped.
      if (do_pop && (fill_ff != '0)) begin
         rd_ptr_in = kwq_pkg::next_ptr(rd_ptr_ff);
         fill_in   = fill_ff - FILL_W'(1);
         dot_in    = dot_new;
         if (head_ff == kwq_pkg::CHAR_SPACE) begin
            phase_in = PH_SPACE;
            count_in = new_x4;
         end else if (head_code.known) begin
            count_in   = head_code.pattern[0] ? new_x3 : new_x1;
            pattern_in = head_code.pattern >> 1;
            left_in    = head_code.length - 3'd1;
            phase_in   = PH_MARK;
         end
      end

      if (csr_write_enable) begin
         case (csr_index)
            kwq_pkg::REG_WPM: begin
               wpm_in = csr_write_data[kwq_pkg::WPM_W-1:0];
            end
            kwq_pkg::REG_KEY_DTR: begin
               key_dtr_in = csr_write_data[0];
            end
            kwq_pkg::REG_ENABLE: begin
               enable_in = csr_write_data[0];
               if (csr_write_data[0] != enable_ff) begin
                  phase_in   = PH_IDLE;
                  pattern_in = '0;
                  left_in    = '0;
                  count_in   = '0;
                  if (csr_write_data[0]) begin
                     rd_ptr_in = '0;
                     wr_ptr_in = '0;
                     fill_in   = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = exec ? 1'b1 : (rsp_valid_ff && rsp_stall);
      key_in       = enable_in && (phase_in == PH_MARK);
      dtr_in       = key_dtr_in ? key_in : 1'b0;
      rts_in       = key_dtr_in ? 1'b0 : key_in;
      qfill_in     = QFILL_W'(fill_in);
      sending_in   = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[wr_ptr_ff] <= front.cmd.char_code;
      end
   end

   // The head register always holds the entry at the next read pointer.
   always_ff @(posedge clock) begin
      if (store_we && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= front.cmd.char_code;
      end else begin
         head_ff <= store_mem[rd_ptr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wpm_ff       <= kwq_pkg::WPM_RESET;
         key_dtr_ff   <= 1'b1;
         enable_ff    <= 1'b0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         fill_ff      <= '0;
         phase_ff     <= PH_IDLE;
         pattern_ff   <= '0;
         left_ff      <= '0;
         count_ff     <= '0;
         dot_ff       <= kwq_pkg::DOT_DEFAULT;
         rsp_valid_ff <= 1'b0;
      end else begin
         wpm_ff       <= wpm_in;
         key_dtr_ff   <= key_dtr_in;
         enable_ff    <= enable_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         fill_ff      <= fill_in;
         phase_ff     <= phase_in;
         pattern_ff   <= pattern_in;
         left_ff      <= left_in;
         count_ff     <= count_in;
         dot_ff       <= dot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (exec) begin
         key_ff      <= key_in;
         dtr_ff      <= dtr_in;
         rts_ff      <= rts_in;
         accepted_ff <= accepted_in;
         qfill_ff    <= qfill_in;
         sending_ff  <= sending_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_key_down   = key_ff;
   assign rsp_dtr_line   = dtr_ff;
   assign rsp_rts_line   = rts_ff;
   assign rsp_accepted   = accepted_ff;
   assign rsp_queue_fill = qfill_ff;
   assign rsp_sending    = sending_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX)
      else $error("Character queue holds more than its capacity.");

   a_idle_when_disabled: assert property (@(posedge clock) disable iff (reset)
      !enable_ff |-> (phase_ff == PH_IDLE))
      else $error("Keyer is sending while disabled.");

   a_key_implies_sending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && key_ff |-> sending_ff && (dtr_ff != rts_ff))
      else $error("Key down without a character in progress.");

   a_push_grows_fill: assert property (@(posedge clock) disable iff (reset)
      exec && accepted_in && !csr_write_enable |=> fill_ff == $past(fill_ff) + FILL_W'(1))
      else $error("Accepted push did not add to the queue fill.");

   a_take_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      exec |=> rsp_valid_ff)
      else $error("Executed command produced no response.");
`endif

endmodule

`default_nettype wire

### design/morse_keyer_with_queue.sv
// A request transfer reaches its response through the two-entry command queue and
// the execute step with its response register.
// Throughput: one item per cycle while rsp_stall is low, set by the execute step.
// Reset is synchronous: pointers, timer, configuration and rsp_valid reset at once;
// no clearing pass; the character store, command slots and response data stay uncleared.
// Top level of the Morse keyer with queue; depends on kwq_pkg and its two submodules.
`timescale 1ns / 1ps
`default_nettype none

module morse_keyer_with_queue (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [kwq_pkg::CMD_W-1:0]         req_cmd,
   input  wire  [kwq_pkg::CHAR_W-1:0]        req_char_code,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic                              rsp_key_down,
   output logic                              rsp_dtr_line,
   output logic                              rsp_rts_line,
   output logic                              rsp_accepted,
   output logic [kwq_pkg::QFILL_W-1:0]       rsp_queue_fill,
   output logic                              rsp_sending,
   input  wire                               csr_write_enable,
   input  wire  [kwq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [kwq_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   kwq_pkg::front_type front;
   logic               take;

   kwq_cmd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_char_code (req_char_code),
      .front         (front),
      .take          (take)
   );

   kwq_keyer_back u_back (
      .clock            (clock),
      .reset            (reset),
      .front            (front),
      .take             (take),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_key_down     (rsp_key_down),
      .rsp_dtr_line     (rsp_dtr_line),
      .rsp_rts_line     (rsp_rts_line),
      .rsp_accepted     (rsp_accepted),
      .rsp_queue_fill   (rsp_queue_fill),
      .rsp_sending      (rsp_sending)
   );

endmodule

`default_nettype wire
